// ===== src/dsci_pkg.sv =====
package dsci_pkg;

   localparam int FRAC_BITS = 16;

   // quotient magnitudes at or above 2**QBITS are clipped
   localparam int QBITS = 35;

   // round(2**32 / (4*pi))
   localparam int INV_W = 29;
   localparam logic [INV_W-1:0] INV_4PI = 29'd341782638;
   localparam int PROD_W = QBITS + INV_W;

   localparam int SQRT_STAGES = 32;
   localparam int SUM_W = 2 * SQRT_STAGES;
   localparam int NUM_BASE_W = 64;
   localparam int NUM_W = NUM_BASE_W + 2 * FRAC_BITS;
   localparam int DEN_W = 96;

   localparam int DIV_LAT = 1 + QBITS;
   localparam int SCALE_LAT = 2;
   localparam int FLAG_LEN = DIV_LAT + SCALE_LAT;
   localparam int TOTAL_LAT = 3 + SQRT_STAGES + 2 + DIV_LAT + SCALE_LAT + 1;

   typedef struct packed {
      logic [63:0] ab;
      logic [63:0] dx;
      logic [63:0] dy;
      logic [31:0] az;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic nxy;
      logic nz;
      logic sing;
   } side_type;

   typedef struct packed {
      logic nxy;
      logic nz;
      logic sing;
   } flag_type;

endpackage

// ===== src/dipole_sheet_corner_integral_top.sv =====
// Corner term of a rectangular dipole sheet's field integral in signed fixed point.
// A request is taken in every cycle (busy stays low) and its result is shown on the
// rsp_ ports for one cycle, marked by rsp_valid; the receiver cannot stall and the block
// never needs it to. Each request passes through three input stages, the 32-stage root
// pipeline (one root bit per stage), two denominator stages, the five 36-stage quotient
// pipelines (one quotient bit per stage, plus a range check), two rounding stages and
// one output register.
module dipole_sheet_corner_integral_top import dsci_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_corner_x,
   input  logic signed [31:0] req_corner_y,
   input  logic signed [31:0] req_height,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_mx_to_x,
   output logic signed [31:0] rsp_cross_term,
   output logic signed [31:0] rsp_mx_to_z,
   output logic signed [31:0] rsp_my_to_y,
   output logic signed [31:0] rsp_my_to_z,
   output logic               rsp_singular,
   output logic               rsp_saturated
);

   logic accept;

   // stage 1: magnitudes and signs
   logic               v1_ff;
   logic [31:0]        ax1_ff, ay1_ff, az1_ff, ax1_in, ay1_in, az1_in;
   logic signed [31:0] x1_ff, y1_ff;
   logic               nxy1_ff, nz1_ff, nxy1_in;

   // stage 2: squares and the x*y product
   logic               v2_ff;
   logic [63:0]        xx2_ff, yy2_ff, zz2_ff, ab2_ff;
   logic [63:0]        xx2_in, yy2_in, zz2_in, ab2_in;
   logic [31:0]        az2_ff;
   logic signed [31:0] x2_ff, y2_ff;
   logic               nxy2_ff, nz2_ff;

   // stage 3: sums
   logic               v3_ff;
   logic [SUM_W-1:0]   sum3_ff;
   side_type           side3_ff, side3_in;

   side_type side_ff [SQRT_STAGES];

   logic                   sq_valid;
   logic [SQRT_STAGES-1:0] sq_root;
   side_type               side_tap;

   // stage A: root minus offsets, partial products of the denominators
   logic               va_ff;
   logic [31:0]        ra_ff;
   logic [32:0]        rmx_a_ff, rmy_a_ff, rmx_a_in, rmy_a_in;
   logic [33:0]        rmx_full, rmy_full;
   logic [63:0]        pxl_ff, pxh_ff, pyl_ff, pyh_ff;
   logic [63:0]        pxl_in, pxh_in, pyl_in, pyh_in;
   logic [63:0]        aba_ff;
   logic [31:0]        aza_ff;
   flag_type           fla_ff;

   // stage B: full denominators and numerators
   logic               vb_ff;
   logic [DEN_W-1:0]   dxd_ff, dyd_ff, dxd_in, dyd_in, rb_ff;
   logic [64:0]        nzx_full, nzy_full;
   logic [63:0]        nzx_ff, nzy_ff, abb_ff;
   flag_type           flb_ff;

   flag_type fl_ff [FLAG_LEN];
   flag_type fl_div, fl_out;

   logic [4:0]       dv;
   logic [QBITS-1:0] dq [5];
   logic [4:0]       dsat;
   logic [4:0]       sv;
   logic [4:0]       ssat;
   logic signed [31:0] sval [5];

   logic               out_v_ff, out_sing_ff, out_sat_ff;
   logic signed [31:0] out_val_ff [5];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      ax1_in  = req_corner_x[31] ? (~$unsigned(req_corner_x) + 32'd1) : $unsigned(req_corner_x);
      ay1_in  = req_corner_y[31] ? (~$unsigned(req_corner_y) + 32'd1) : $unsigned(req_corner_y);
      az1_in  = req_height[31] ? (~$unsigned(req_height) + 32'd1) : $unsigned(req_height);
      nxy1_in = (req_corner_x != 32'sd0) && (req_corner_y != 32'sd0) &&
                (req_corner_x[31] == req_corner_y[31]);
   end

   assign xx2_in = ax1_ff * ax1_ff;
   assign yy2_in = ay1_ff * ay1_ff;
   assign zz2_in = az1_ff * az1_ff;
   assign ab2_in = ax1_ff * ay1_ff;

   always_comb begin
      side3_in.ab   = ab2_ff;
      side3_in.dx   = xx2_ff + zz2_ff;
      side3_in.dy   = yy2_ff + zz2_ff;
      side3_in.az   = az2_ff;
      side3_in.x    = x2_ff;
      side3_in.y    = y2_ff;
      side3_in.nxy  = nxy2_ff;
      side3_in.nz   = nz2_ff;
      // a denominator vanishes only when height and one offset are both zero
      side3_in.sing = (zz2_ff == 64'd0) && ((xx2_ff == 64'd0) || (yy2_ff == 64'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      ax1_ff  <= ax1_in;
      ay1_ff  <= ay1_in;
      az1_ff  <= az1_in;
      x1_ff   <= req_corner_x;
      y1_ff   <= req_corner_y;
      nxy1_ff <= nxy1_in;
      nz1_ff  <= req_height[31];

      xx2_ff  <= xx2_in;
      yy2_ff  <= yy2_in;
      zz2_ff  <= zz2_in;
      ab2_ff  <= ab2_in;
      az2_ff  <= az1_ff;
      x2_ff   <= x1_ff;
      y2_ff   <= y1_ff;
      nxy2_ff <= nxy1_ff;
      nz2_ff  <= nz1_ff;

      sum3_ff  <= xx2_ff + yy2_ff + zz2_ff;
      side3_ff <= side3_in;
   end

   dsci_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (v3_ff),
      .op_sum    (sum3_ff),
      .res_valid (sq_valid),
      .res_root  (sq_root)
   );

   // side data follows the root pipeline
   always_ff @(posedge clock) begin
      side_ff[0] <= side3_ff;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign side_tap = side_ff[SQRT_STAGES-1];

   always_comb begin
      rmx_full = {2'b00, sq_root} - {{2{side_tap.x[31]}}, $unsigned(side_tap.x)};
      rmy_full = {2'b00, sq_root} - {{2{side_tap.y[31]}}, $unsigned(side_tap.y)};
      rmx_a_in = rmx_full[32:0];
      rmy_a_in = rmy_full[32:0];
      pxl_in   = sq_root * side_tap.dx[31:0];
      pxh_in   = sq_root * side_tap.dx[63:32];
      pyl_in   = sq_root * side_tap.dy[31:0];
      pyh_in   = sq_root * side_tap.dy[63:32];
   end

   always_comb begin
      dxd_in   = {32'd0, pxl_ff} + {pxh_ff, 32'd0};
      dyd_in   = {32'd0, pyl_ff} + {pyh_ff, 32'd0};
      nzx_full = aza_ff * rmy_a_ff;
      nzy_full = aza_ff * rmx_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= sq_valid;
         vb_ff <= va_ff;
      end
      ra_ff      <= sq_root;
      rmx_a_ff   <= rmx_a_in;
      rmy_a_ff   <= rmy_a_in;
      pxl_ff     <= pxl_in;
      pxh_ff     <= pxh_in;
      pyl_ff     <= pyl_in;
      pyh_ff     <= pyh_in;
      aba_ff     <= side_tap.ab;
      aza_ff     <= side_tap.az;
      fla_ff.nxy <= side_tap.nxy;
      fla_ff.nz  <= side_tap.nz;
      fla_ff.sing <= side_tap.sing;

      dxd_ff <= dxd_in;
      dyd_ff <= dyd_in;
      rb_ff  <= DEN_W'(ra_ff);
      nzx_ff <= nzx_full[63:0];
      nzy_ff <= nzy_full[63:0];
      abb_ff <= aba_ff;
      flb_ff <= fla_ff;
   end

   dsci_div u_div_mxx (
      .clock (clock), .reset (reset), .op_valid (vb_ff),
      .op_num (abb_ff), .op_den (dxd_ff),
      .res_valid (dv[0]), .res_quot (dq[0]), .res_sat (dsat[0])
   );

   dsci_div u_div_cross (
      .clock (clock), .reset (reset), .op_valid (vb_ff),
      .op_num (64'd1), .op_den (rb_ff),
      .res_valid (dv[1]), .res_quot (dq[1]), .res_sat (dsat[1])
   );

   dsci_div u_div_mxz (
      .clock (clock), .reset (reset), .op_valid (vb_ff),
      .op_num (nzx_ff), .op_den (dxd_ff),
      .res_valid (dv[2]), .res_quot (dq[2]), .res_sat (dsat[2])
   );

   dsci_div u_div_myy (
      .clock (clock), .reset (reset), .op_valid (vb_ff),
      .op_num (abb_ff), .op_den (dyd_ff),
      .res_valid (dv[3]), .res_quot (dq[3]), .res_sat (dsat[3])
   );

   dsci_div u_div_myz (
      .clock (clock), .reset (reset), .op_valid (vb_ff),
      .op_num (nzy_ff), .op_den (dyd_ff),
      .res_valid (dv[4]), .res_quot (dq[4]), .res_sat (dsat[4])
   );

   always_ff @(posedge clock) begin
      fl_ff[0] <= flb_ff;
      for (int i = 1; i < FLAG_LEN; i++) begin
         fl_ff[i] <= fl_ff[i-1];
      end
   end

   assign fl_div = fl_ff[DIV_LAT-1];
   assign fl_out = fl_ff[FLAG_LEN-1];

   dsci_scale u_scale_mxx (
      .clock (clock), .reset (reset), .op_valid (dv[0]),
      .op_quot (dq[0]), .op_sat (dsat[0]), .op_neg (fl_div.nxy),
      .res_valid (sv[0]), .res_value (sval[0]), .res_sat (ssat[0])
   );

   dsci_scale u_scale_cross (
      .clock (clock), .reset (reset), .op_valid (dv[1]),
      .op_quot (dq[1]), .op_sat (dsat[1]), .op_neg (1'b0),
      .res_valid (sv[1]), .res_value (sval[1]), .res_sat (ssat[1])
   );

   dsci_scale u_scale_mxz (
      .clock (clock), .reset (reset), .op_valid (dv[2]),
      .op_quot (dq[2]), .op_sat (dsat[2]), .op_neg (fl_div.nz),
      .res_valid (sv[2]), .res_value (sval[2]), .res_sat (ssat[2])
   );

   dsci_scale u_scale_myy (
      .clock (clock), .reset (reset), .op_valid (dv[3]),
      .op_quot (dq[3]), .op_sat (dsat[3]), .op_neg (fl_div.nxy),
      .res_valid (sv[3]), .res_value (sval[3]), .res_sat (ssat[3])
   );

   dsci_scale u_scale_myz (
      .clock (clock), .reset (reset), .op_valid (dv[4]),
      .op_quot (dq[4]), .op_sat (dsat[4]), .op_neg (fl_div.nz),
      .res_valid (sv[4]), .res_value (sval[4]), .res_sat (ssat[4])
   );

   // singular point overrides every component
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= &sv;
      end
      out_sing_ff <= fl_out.sing;
      out_sat_ff  <= !fl_out.sing && (|ssat);
      for (int i = 0; i < 5; i++) begin
         out_val_ff[i] <= fl_out.sing ? 32'sd0 : sval[i];
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_mx_to_x    = out_val_ff[0];
   assign rsp_cross_term = out_val_ff[1];
   assign rsp_mx_to_z    = out_val_ff[2];
   assign rsp_my_to_y    = out_val_ff[3];
   assign rsp_my_to_z    = out_val_ff[4];
   assign rsp_singular   = out_sing_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

// ===== src/dsci_sqrt.sv =====
module dsci_sqrt import dsci_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  logic [SUM_W-1:0]       op_sum,
   output logic                   res_valid,
   output logic [SQRT_STAGES-1:0] res_root
);

   logic [SQRT_STAGES-1:0] vld_ff, vld_in;
   logic [SUM_W-1:0]       sum_ff  [SQRT_STAGES];
   logic [SUM_W-1:0]       sum_in  [SQRT_STAGES];
   logic [SQRT_STAGES+1:0] rem_ff  [SQRT_STAGES];
   logic [SQRT_STAGES+1:0] rem_in  [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] root_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] root_in [SQRT_STAGES];

   // one root bit per stage, two radicand bits taken from the top each time
   always_comb begin
      logic [SUM_W-1:0]       s_prev;
      logic [SQRT_STAGES+1:0] r_prev;
      logic [SQRT_STAGES-1:0] q_prev;
      logic                   v_prev;
      logic [SQRT_STAGES+3:0] t;
      logic [SQRT_STAGES+3:0] trial;
      logic [SQRT_STAGES+3:0] diff;
      for (int i = 0; i < SQRT_STAGES; i++) begin
         if (i == 0) begin
            s_prev = op_sum;
            r_prev = '0;
            q_prev = '0;
            v_prev = op_valid;
         end else begin
            s_prev = sum_ff[i-1];
            r_prev = rem_ff[i-1];
            q_prev = root_ff[i-1];
            v_prev = vld_ff[i-1];
         end
         t = {r_prev, s_prev[SUM_W-1:SUM_W-2]};
         trial = {2'b00, q_prev, 2'b01};
         diff = t - trial;
         vld_in[i] = v_prev;
         sum_in[i] = {s_prev[SUM_W-3:0], 2'b00};
         if (t >= trial) begin
            rem_in[i]  = diff[SQRT_STAGES+1:0];
            root_in[i] = {q_prev[SQRT_STAGES-2:0], 1'b1};
         end else begin
            rem_in[i]  = t[SQRT_STAGES+1:0];
            root_in[i] = {q_prev[SQRT_STAGES-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      for (int i = 0; i < SQRT_STAGES; i++) begin
         sum_ff[i]  <= sum_in[i];
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
   end

   assign res_valid = vld_ff[SQRT_STAGES-1];
   assign res_root  = root_ff[SQRT_STAGES-1];

endmodule

// ===== src/dsci_div.sv =====
module dsci_div import dsci_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  op_valid,
   input  logic [NUM_BASE_W-1:0] op_num,
   input  logic [DEN_W-1:0]      op_den,
   output logic                  res_valid,
   output logic [QBITS-1:0]      res_quot,
   output logic                  res_sat
);

   logic [NUM_W-1:0]       n_full;
   logic [NUM_W-QBITS-1:0] head;
   logic [DEN_W-1:0]       head_ext;

   logic             pv_ff;
   logic [DEN_W-1:0] prem_ff, pden_ff;
   logic [QBITS-1:0] plow_ff;
   logic             psat_ff;

   logic [QBITS-1:0] vld_ff, vld_in, sat_ff, sat_in;
   logic [DEN_W-1:0] rem_ff [QBITS];
   logic [DEN_W-1:0] rem_in [QBITS];
   logic [DEN_W-1:0] den_ff [QBITS];
   logic [DEN_W-1:0] den_in [QBITS];
   logic [QBITS-1:0] low_ff [QBITS];
   logic [QBITS-1:0] low_in [QBITS];
   logic [QBITS-1:0] quot_ff [QBITS];
   logic [QBITS-1:0] quot_in [QBITS];

   // the high part of the numerator must stay below the divisor, else clip
   assign n_full   = {op_num, {(2 * FRAC_BITS){1'b0}}};
   assign head     = n_full[NUM_W-1:QBITS];
   assign head_ext = DEN_W'(head);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= op_valid;
      end
      prem_ff <= head_ext;
      pden_ff <= op_den;
      plow_ff <= n_full[QBITS-1:0];
      psat_ff <= (head_ext >= op_den);
   end

   always_comb begin
      logic [DEN_W-1:0] r_prev, d_prev;
      logic [QBITS-1:0] l_prev, q_prev;
      logic             v_prev, s_prev;
      logic [DEN_W:0]   t, diff;
      for (int i = 0; i < QBITS; i++) begin
         if (i == 0) begin
            r_prev = prem_ff;
            d_prev = pden_ff;
            l_prev = plow_ff;
            q_prev = '0;
            v_prev = pv_ff;
            s_prev = psat_ff;
         end else begin
            r_prev = rem_ff[i-1];
            d_prev = den_ff[i-1];
            l_prev = low_ff[i-1];
            q_prev = quot_ff[i-1];
            v_prev = vld_ff[i-1];
            s_prev = sat_ff[i-1];
         end
         t = {r_prev, l_prev[QBITS-1]};
         diff = t - {1'b0, d_prev};
         vld_in[i] = v_prev;
         sat_in[i] = s_prev;
         den_in[i] = d_prev;
         low_in[i] = {l_prev[QBITS-2:0], 1'b0};
         if (t >= {1'b0, d_prev}) begin
            rem_in[i]  = diff[DEN_W-1:0];
            quot_in[i] = {q_prev[QBITS-2:0], 1'b1};
         end else begin
            rem_in[i]  = t[DEN_W-1:0];
            quot_in[i] = {q_prev[QBITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      sat_ff <= sat_in;
      for (int i = 0; i < QBITS; i++) begin
         rem_ff[i]  <= rem_in[i];
         den_ff[i]  <= den_in[i];
         low_ff[i]  <= low_in[i];
         quot_ff[i] <= quot_in[i];
      end
   end

   assign res_valid = vld_ff[QBITS-1];
   assign res_quot  = quot_ff[QBITS-1];
   assign res_sat   = sat_ff[QBITS-1];

endmodule

// ===== src/dsci_scale.sv =====
module dsci_scale import dsci_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   input  logic [QBITS-1:0]   op_quot,
   input  logic               op_sat,
   input  logic               op_neg,
   output logic               res_valid,
   output logic signed [31:0] res_value,
   output logic               res_sat
);

   logic [PROD_W-1:0] prod_in, prod_ff;
   logic              v1_ff, sat1_ff, neg1_ff;
   logic [PROD_W-1:0] rnd;
   logic [31:0]       mag, limit, mag_c;
   logic              clip;
   logic              v2_ff, sat2_ff;
   logic [31:0]       val2_ff, val2_in;

   assign prod_in = op_quot * INV_4PI;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= op_valid;
         v2_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      sat1_ff <= op_sat;
      neg1_ff <= op_neg;
      val2_ff <= val2_in;
      sat2_ff <= clip;
   end

   // round to nearest, then clip to the signed range of the sign in force
   always_comb begin
      rnd   = prod_ff + PROD_W'(64'h8000_0000);
      mag   = rnd[PROD_W-1:PROD_W-32];
      limit = neg1_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      clip  = sat1_ff || (mag > limit);
      mag_c = clip ? limit : mag;
      val2_in = neg1_ff ? (~mag_c + 32'd1) : mag_c;
   end

   assign res_valid = v2_ff;
   assign res_value = $signed(val2_ff);
   assign res_sat   = sat2_ff;

endmodule

// ===== src/dsci_checker.sv =====
module dsci_checker import dsci_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_mx_to_x,
   input logic signed [31:0] rsp_cross_term,
   input logic signed [31:0] rsp_mx_to_z,
   input logic signed [31:0] rsp_my_to_y,
   input logic signed [31:0] rsp_my_to_z,
   input logic               rsp_singular,
   input logic               rsp_saturated
);

   // every request taken comes out after the fixed latency
   a_request_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LAT rsp_valid)
      else $error("request without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LAT))
      else $error("result without request");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_mx_to_x == 32'sd0 && rsp_cross_term == 32'sd0 &&
         rsp_mx_to_z == 32'sd0 && rsp_my_to_y == 32'sd0 && rsp_my_to_z == 32'sd0 &&
         !rsp_saturated))
      else $error("singular result not cleared");

   a_cross_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_cross_term[31])
      else $error("negative cross term");

endmodule

bind dipole_sheet_corner_integral_top dsci_checker u_dsci_checker (.*);

// ===== verif/tb_dipole_sheet_corner_integral_top.sv =====
module tb_dipole_sheet_corner_integral_top;
   import dsci_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] mx_to_x;
      logic signed [31:0] cross_term;
      logic signed [31:0] mx_to_z;
      logic signed [31:0] my_to_y;
      logic signed [31:0] my_to_z;
      logic               singular;
      logic               saturated;
   } field_set_type;

   localparam logic [63:0] INV_4PI_SCALE = 64'd341782638;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_corner_x = '0;
   logic signed [31:0] req_corner_y = '0;
   logic signed [31:0] req_height = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_mx_to_x, rsp_cross_term, rsp_mx_to_z, rsp_my_to_y, rsp_my_to_z;
   logic               rsp_singular, rsp_saturated;

   field_set_type pending_fields[$];
   int         failures = 0;
   bit         quiet = 1'b0;
   logic       busy_seen;

   dipole_sheet_corner_integral_top dut (.*);

   always #1 clock = ~clock;

   // busy as it stood during the cycle that the next edge ends
   always @(negedge clock) busy_seen <= busy;

   function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] acc, trial;
      acc = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = acc | (64'd1 << i);
         if (trial * trial <= s) acc = trial;
      end
      return acc;
   endfunction

   function automatic logic [31:0] scaled_part(logic [63:0] a, logic [63:0] b,
         logic [63:0] d1, logic [63:0] d2, logic neg, ref logic sat);
      logic [127:0] num, den, q;
      logic [63:0]  mag, limit;
      num = ({64'd0, a} * {64'd0, b}) << (2 * FRAC_BITS);
      den = {64'd0, d1} * {64'd0, d2};
      q = num / den;
      limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      if (q >= (128'd1 << QBITS)) begin
         mag = limit;
         sat = 1'b1;
      end else begin
         mag = (q[63:0] * INV_4PI_SCALE + 64'h8000_0000) >> 32;
         if (mag > limit) begin
            mag = limit;
            sat = 1'b1;
         end
      end
      return neg ? 32'(-mag) : mag[31:0];
   endfunction

   function automatic field_set_type corner_fields(logic signed [31:0] x,
         logic signed [31:0] y, logic signed [31:0] z);
      field_set_type f;
      logic signed [63:0] xs, ys, zs;
      logic [63:0] ax, ay, az, dx, dy, r;
      logic sat, nxy, nz;
      xs = x;
      ys = y;
      zs = z;
      ax = xs < 0 ? -xs : xs;
      ay = ys < 0 ? -ys : ys;
      az = zs < 0 ? -zs : zs;
      dx = ax * ax + az * az;
      dy = ay * ay + az * az;
      sat = 1'b0;
      nxy = (x != 0) && (y != 0) && (x[31] == y[31]);
      nz = z[31];
      f = '{default: '0};
      if (dx == 0 || dy == 0) begin
         f.singular = 1'b1;
         return f;
      end
      r = root_floor(ax * ax + ay * ay + az * az);
      f.mx_to_x = scaled_part(ax, ay, r, dx, nxy, sat);
      f.cross_term = scaled_part(64'd1, 64'd1, r, 64'd1, 1'b0, sat);
      f.mx_to_z = scaled_part(az, 64'($signed(r) - ys), r, dx, nz, sat);
      f.my_to_y = scaled_part(ax, ay, r, dy, nxy, sat);
      f.my_to_z = scaled_part(az, 64'($signed(r) - xs), r, dy, nz, sat);
      f.saturated = sat;
      return f;
   endfunction

   task automatic send_corner(logic signed [31:0] x, logic signed [31:0] y,
         logic signed [31:0] z);
      logic held;
      start <= 1'b1;
      req_corner_x <= x;
      req_corner_y <= y;
      req_height <= z;
      do begin
         @(posedge clock);
         held = busy_seen;
      end while (held);
      pending_fields.push_back(corner_fields(x, y, z));
      // a low chance of a pause keeps idling near 15 in 100
      if (!quiet && $urandom_range(99) < 5) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_fields.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            field_set_type e;
            e = pending_fields.pop_front();
            if (rsp_mx_to_x !== e.mx_to_x) begin
               $error("mx_to_x expected %0d got %0d", e.mx_to_x, rsp_mx_to_x); failures++;
            end
            if (rsp_cross_term !== e.cross_term) begin
               $error("cross_term expected %0d got %0d", e.cross_term, rsp_cross_term);
               failures++;
            end
            if (rsp_mx_to_z !== e.mx_to_z) begin
               $error("mx_to_z expected %0d got %0d", e.mx_to_z, rsp_mx_to_z); failures++;
            end
            if (rsp_my_to_y !== e.my_to_y) begin
               $error("my_to_y expected %0d got %0d", e.my_to_y, rsp_my_to_y); failures++;
            end
            if (rsp_my_to_z !== e.my_to_z) begin
               $error("my_to_z expected %0d got %0d", e.my_to_z, rsp_my_to_z); failures++;
            end
            if (rsp_singular !== e.singular) begin
               $error("singular expected %0d got %0d", e.singular, rsp_singular); failures++;
            end
            if (rsp_saturated !== e.saturated) begin
               $error("saturated expected %0d got %0d", e.saturated, rsp_saturated);
               failures++;
            end
         end
      end
   end

   function automatic logic signed [31:0] some_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom) >>> $urandom_range(8, 24);
         2: return $signed($urandom_range(0, 1) ? 32'sd1 : -32'sd1) * $urandom_range(0, 3);
         default: return $signed($urandom) >>> $urandom_range(14, 20);
      endcase
   endfunction

   task automatic test_singular_points();
      send_corner(0, 0, 0);
      send_corner(32'sh0001_0000, 0, 0);
      send_corner(0, -32'sh0003_0000, 0);
      send_corner(32'sh7fff_ffff, 0, 0);
      send_corner(0, 32'sh8000_0000, 0);
   endtask

   task automatic test_extremes();
      send_corner(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_corner(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_corner(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
      send_corner(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      send_corner(0, 0, 1);
      send_corner(0, 0, -1);
      send_corner(1, 1, 1);
      send_corner(-1, -1, -1);
      send_corner(0, 0, 32'sh0001_0000);
      send_corner(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
      send_corner(-32'sh0001_0000, 32'sh0002_0000, -32'sh0000_8000);
      send_corner(32'sh0005_0000, -32'sh0005_0000, 0);
      send_corner(32'sh0000_0100, 32'sh0000_0100, 32'sh0000_0010);
      send_corner(32'sh8000_0000, 0, 32'sh0000_0001);
      send_corner(0, 32'sh7fff_ffff, -32'sh0000_0001);
   endtask

   task automatic test_random_corners(int count);
      for (int i = 0; i < count; i++) begin
         quiet = (i >= count / 3) && (i < count / 2);
         if (i == count * 3 / 4) drain_results();
         if ($urandom_range(19) == 0) send_corner(some_coord(), some_coord(), 0);
         else send_corner(some_coord(), some_coord(), some_coord());
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_singular_points();
      test_extremes();
      drain_results();
      test_random_corners(600);
      drain_results();
      repeat (TOTAL_LAT + 10) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #500us;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== dipole_sheet_corner_integral_top.f =====
src/dsci_pkg.sv
src/dsci_sqrt.sv
src/dsci_div.sv
src/dsci_scale.sv
src/dipole_sheet_corner_integral_top.sv
src/dsci_checker.sv
verif/tb_dipole_sheet_corner_integral_top.sv
